>>> rtl/atrp_pkg.sv
// Shared types, widths and constants for the accelerometer tilt pipeline.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package atrp_pkg;

    localparam int IN_W       = 16;   // accelerometer sample width
    localparam int IN_SHIFT   = 16;   // samples enter the vector path as counts * 2^16
    localparam int VW         = 36;   // CORDIC vector component width
    localparam int AW         = 34;   // Q30 angle accumulator width
    localparam int ROLL_W     = 16;
    localparam int PITCH_W    = 15;
    localparam int GAIN_PW    = 48;   // negated x times CORDIC gain
    localparam int GAIN_SHIFT = 14;   // 2^16 input scale folded into the Q30 shift
    localparam int CENTI_PW   = 48;   // angle times centidegree scale
    localparam int CENTI_SHIFT = 30;

    localparam logic signed [AW-1:0]       PI_Q30      = 34'sd3373259426;
    localparam logic signed [31:0]         GAIN_Q30    = 32'sd1768195363;
    localparam logic signed [14:0]         CENTI_SCALE = 15'sd5730;
    localparam logic signed [CENTI_PW-1:0] CENTI_HALF  = 48'sd536870912;

    // One item in flight through a CORDIC pass, with the data riding alongside it.
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 zero;
        logic signed [VW-1:0] carry_y;
        logic signed [AW-1:0] carry_ang;
    } cordic_t;

    typedef struct packed {
        logic signed [AW-1:0] roll;
        logic signed [AW-1:0] pitch;
    } angles_t;

    // atan(2^-idx) in Q30 radians.
    function automatic logic signed [AW-1:0] atan_step(input int unsigned idx);
        logic signed [AW-1:0] r;
        r = '0;
        case (idx)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default:
            begin
                if (idx <= 30)
                    r = {{(AW-1){1'b0}}, 1'b1} << (30 - idx);
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/accel_tilt_roll_pitch_top.sv
// Top level of the accelerometer tilt pipeline: input stage, roll and pitch CORDIC passes,
// centidegree conversion. Depends on atrp_pkg, atrp_cordic and atrp_centi.
`default_nettype none

// Roll and pitch from one three-axis accelerometer beat. Each accepted beat on the slave
// stream gives exactly one beat on the master stream: roll = atan2(y, z) and
// pitch = atan2(-x, |(y, z)|), both as radians times 5730 (hundredths of a degree at
// 57.3 degrees per radian), rounded half up. atan2(0, 0) reads as 0, and a zero ordinate
// with a negative abscissa reads as +pi. The design is a fully pipelined chain: one input
// register stage (which also scales -x by the CORDIC gain), a roll vectoring pass and a
// pitch vectoring pass of ANGLE_ITERATIONS + 1 stages each (one quadrant stage, then one
// micro-rotation per stage), and two conversion stages (multiply, round). A new beat is
// taken in every cycle while the output is not stalled. Every stage has its own valid bit
// and fills a bubble while the output is stalled, so the slave side keeps accepting until
// the pipeline is full; no beat is dropped or repeated under backpressure. There are no
// configuration registers and no state between beats. ANGLE_ITERATIONS may be set from
// 10 to 24; it sets the depth of both vectoring passes and the angle resolution.
module accel_tilt_roll_pitch_top #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] roll_centideg, [30:16] pitch_centideg, [31] 0
);
    import atrp_pkg::*;

    // Input stage: split the beat and scale -x by the CORDIC gain.
    logic signed [IN_W-1:0]    accel_x;
    logic signed [IN_W-1:0]    accel_y;
    logic signed [IN_W-1:0]    accel_z;
    logic signed [IN_W:0]      neg_x;
    logic signed [GAIN_PW-1:0] gain_prod;
    logic signed [GAIN_PW-1:0] gain_shifted;

    logic                      s0_valid_reg;
    logic signed [IN_W-1:0]    s0_x_reg;
    logic signed [IN_W-1:0]    s0_y_reg;
    logic signed [IN_W-1:0]    s0_z_reg;
    logic signed [VW-1:0]      s0_ny_reg;

    logic    roll_in_ready;
    cordic_t roll_in;
    logic    roll_out_valid;
    logic    roll_out_ready;
    cordic_t roll_out;

    cordic_t pitch_in;
    logic    pitch_out_valid;
    logic    pitch_out_ready;
    cordic_t pitch_out;

    angles_t                   angles;
    logic signed [ROLL_W-1:0]  roll_centideg;
    logic signed [PITCH_W-1:0] pitch_centideg;

    assign accel_x = s_axis_tdata[15:0];
    assign accel_y = s_axis_tdata[31:16];
    assign accel_z = s_axis_tdata[47:32];

    always_comb
    begin
        neg_x        = -{accel_x[IN_W-1], accel_x};
        gain_prod    = neg_x * GAIN_Q30;
        // input scale 2^16 and the Q30 gain shift fold into one floor shift
        gain_shifted = gain_prod >>> GAIN_SHIFT;
    end

    assign s_axis_tready = !s0_valid_reg || roll_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s0_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s0_x_reg  <= accel_x;
            s0_y_reg  <= accel_y;
            s0_z_reg  <= accel_z;
            s0_ny_reg <= gain_shifted[VW-1:0];
        end
    end

    // Roll pass: vector (z, y); carry the gain-scaled -x along for the pitch pass.
    always_comb
    begin
        roll_in           = '0;
        roll_in.x         = {{(VW-IN_W-IN_SHIFT){s0_z_reg[IN_W-1]}}, s0_z_reg, {IN_SHIFT{1'b0}}};
        roll_in.y         = {{(VW-IN_W-IN_SHIFT){s0_y_reg[IN_W-1]}}, s0_y_reg, {IN_SHIFT{1'b0}}};
        roll_in.carry_y   = s0_ny_reg;
        roll_in.carry_ang = '0;
    end

    atrp_cordic #(
        .ITERATIONS (ANGLE_ITERATIONS)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (roll_in_ready),
        .in_data   (roll_in),
        .out_valid (roll_out_valid),
        .out_ready (roll_out_ready),
        .out_data  (roll_out)
    );

    // Pitch pass: vector (gain-scaled magnitude, gain-scaled -x); hold the roll angle.
    always_comb
    begin
        pitch_in           = '0;
        pitch_in.x         = roll_out.x;
        pitch_in.y         = roll_out.carry_y;
        pitch_in.carry_ang = roll_out.zero ? '0 : roll_out.acc;
    end

    atrp_cordic #(
        .ITERATIONS (ANGLE_ITERATIONS)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (roll_out_valid),
        .in_ready  (roll_out_ready),
        .in_data   (pitch_in),
        .out_valid (pitch_out_valid),
        .out_ready (pitch_out_ready),
        .out_data  (pitch_out)
    );

    // Drop the pitch angle of a zero vector; convert both to centidegrees.
    always_comb
    begin
        angles.roll  = pitch_out.carry_ang;
        angles.pitch = pitch_out.zero ? '0 : pitch_out.acc;
    end

    atrp_centi u_centi (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pitch_out_valid),
        .in_ready       (pitch_out_ready),
        .in_data        (angles),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .roll_centideg  (roll_centideg),
        .pitch_centideg (pitch_centideg)
    );

    assign m_axis_tdata = {1'b0, pitch_centideg, roll_centideg};

    a_gain_sign_pos: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && (s0_x_reg > 0) |-> s0_ny_reg < 0)
        else $error("gain-scaled -x has the wrong sign");

    a_gain_sign_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && (s0_x_reg == 0) |-> s0_ny_reg == 0)
        else $error("gain-scaled -x is not zero for zero x");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (roll_centideg >= -16'sd18002) && (roll_centideg <= 16'sd18002))
        else $error("roll outside half a turn");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pitch_centideg >= -15'sd9001) && (pitch_centideg <= 15'sd9001))
        else $error("pitch outside a quarter turn");

endmodule

`default_nettype wire

>>> rtl/atrp_rot_stage.sv
// One registered CORDIC vectoring micro-rotation with its own valid/ready stage.
// Depends on atrp_pkg.
`default_nettype none

module atrp_rot_stage #(
    parameter int SHIFT = 0
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  atrp_pkg::cordic_t in_data,
    output logic              out_valid,
    input  wire               out_ready,
    output atrp_pkg::cordic_t out_data
);
    import atrp_pkg::*;

    localparam logic signed [AW-1:0] ATAN_STEP = atan_step(SHIFT);

    logic                 valid_reg;
    cordic_t              data_reg;
    cordic_t              data_next;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    always_comb
    begin
        data_next = in_data;
        dx        = in_data.y >>> SHIFT;
        dy        = in_data.x >>> SHIFT;
        // rotate towards the x axis; a zero ordinate turns as a positive one
        if (!in_data.y[VW-1])
        begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + ATAN_STEP;
        end
        else
        begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - ATAN_STEP;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/atrp_cordic.sv
// One CORDIC vectoring pass: quadrant pre-rotation stage then a chain of micro-rotations.
// Depends on atrp_pkg and atrp_rot_stage.
`default_nettype none

module atrp_cordic #(
    parameter int ITERATIONS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  atrp_pkg::cordic_t in_data,
    output logic              out_valid,
    input  wire               out_ready,
    output atrp_pkg::cordic_t out_data
);
    import atrp_pkg::*;

    logic    pre_valid_reg;
    cordic_t pre_data_reg;
    cordic_t pre_data_next;

    logic    chain_valid [ITERATIONS+1];
    logic    chain_ready [ITERATIONS+1];
    cordic_t chain_data  [ITERATIONS+1];

    // Flag the zero vector; turn a left-half vector by pi into the right half.
    always_comb
    begin
        pre_data_next      = in_data;
        pre_data_next.acc  = '0;
        pre_data_next.zero = (in_data.x == '0) && (in_data.y == '0);
        if (!pre_data_next.zero && in_data.x[VW-1])
        begin
            pre_data_next.x   = -in_data.x;
            pre_data_next.y   = -in_data.y;
            pre_data_next.acc = in_data.y[VW-1] ? -PI_Q30 : PI_Q30;
        end
    end

    assign in_ready = !pre_valid_reg || chain_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (in_ready)
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pre_data_reg <= pre_data_next;
    end

    assign chain_valid[0] = pre_valid_reg;
    assign chain_data[0]  = pre_data_reg;

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_rot
        atrp_rot_stage #(
            .SHIFT (g)
        ) u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    assign out_valid               = chain_valid[ITERATIONS];
    assign chain_ready[ITERATIONS] = out_ready;
    assign out_data                = chain_data[ITERATIONS];

    a_pre_right_half: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |-> !chain_data[0].x[VW-1])
        else $error("pre-rotation left a negative abscissa");

    a_pre_zero_acc: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] && chain_data[0].zero |-> chain_data[0].acc == '0)
        else $error("zero vector entered the chain with a start angle");

    a_zero_stays_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero |-> out_data.x == '0 && out_data.y == '0)
        else $error("zero vector grew during rotation");

endmodule

`default_nettype wire

>>> rtl/atrp_centi.sv
// Angle conversion from Q30 radians to rounded centidegree units (times 5730).
// Two stages: multiply, then round and shift. Depends on atrp_pkg.
`default_nettype none

module atrp_centi (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  atrp_pkg::angles_t                in_data,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic signed [atrp_pkg::ROLL_W-1:0]  roll_centideg,
    output logic signed [atrp_pkg::PITCH_W-1:0] pitch_centideg
);
    import atrp_pkg::*;

    logic                       mul_valid_reg;
    logic                       mul_ready;
    logic signed [CENTI_PW-1:0] roll_prod_reg;
    logic signed [CENTI_PW-1:0] pitch_prod_reg;
    logic signed [CENTI_PW-1:0] roll_prod_next;
    logic signed [CENTI_PW-1:0] pitch_prod_next;

    logic                       rnd_valid_reg;
    logic signed [ROLL_W-1:0]   roll_reg;
    logic signed [PITCH_W-1:0]  pitch_reg;
    logic signed [CENTI_PW-1:0] roll_rnd;
    logic signed [CENTI_PW-1:0] pitch_rnd;

    always_comb
    begin
        roll_prod_next  = in_data.roll * CENTI_SCALE;
        pitch_prod_next = in_data.pitch * CENTI_SCALE;
        // round half up, floor shift
        roll_rnd  = (roll_prod_reg + CENTI_HALF) >>> CENTI_SHIFT;
        pitch_rnd = (pitch_prod_reg + CENTI_HALF) >>> CENTI_SHIFT;
    end

    assign in_ready  = !mul_valid_reg || mul_ready;
    assign mul_ready = !rnd_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                mul_valid_reg <= in_valid;
            if (mul_ready)
                rnd_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            roll_prod_reg  <= roll_prod_next;
            pitch_prod_reg <= pitch_prod_next;
        end
        if (mul_valid_reg && mul_ready)
        begin
            roll_reg  <= roll_rnd[ROLL_W-1:0];
            pitch_reg <= pitch_rnd[PITCH_W-1:0];
        end
    end

    assign out_valid      = rnd_valid_reg;
    assign roll_centideg  = roll_reg;
    assign pitch_centideg = pitch_reg;

endmodule

`default_nettype wire

>>> verif/tb_accel_tilt_roll_pitch_top.sv
// Self-checking testbench for accel_tilt_roll_pitch_top: streams accelerometer samples in,
// predicts roll and pitch with a bit-exact CORDIC model, and checks every output beat.
// Depends on the rtl top level only; no files, plusargs or seeds are read.
module tb_accel_tilt_roll_pitch_top;

    // Pipeline depth at the default iteration count.
    localparam int ITERATIONS  = 16;
    localparam int LATENCY     = 2 * ITERATIONS + 5;
    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 1600;

    // Fixed-point constants of the angle arithmetic.
    localparam longint COUNT_SCALE = 64'sd65536;      // counts enter as counts * 2^16
    localparam longint HALF_TURN   = 64'sd3373259426; // pi in Q30
    localparam longint CORDIC_GAIN = 64'sd1768195363; // vectoring gain in Q30
    localparam longint CENTI_MUL   = 64'sd5730;       // radians to hundredths at 57.3

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } tilt_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic [47:0] s_tdata;
    logic        m_tready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;

    tilt_t pending_tilts[$];   // predicted angles, oldest first
    int    mismatches;
    int    cycle_count;
    bit    calm;               // when set, neither side idles

    accel_tilt_roll_pitch_top #(
        .ANGLE_ITERATIONS(ITERATIONS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata)     // [15:0] roll_centideg, [30:16] pitch_centideg, [31] 0
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------

    // Arithmetic shift that rounds toward minus infinity; huge shifts saturate.
    function automatic longint floor_shift(input longint v, input int unsigned s);
        if (s > 62)
            return (v < 0) ? -64'sd1 : 64'sd0;
        return v >>> s;
    endfunction

    // Micro-rotation angle atan(2^-i) in Q30; exact powers of two past the table head.
    function automatic longint micro_angle(input int unsigned i);
        case (i)
            0: return 64'sd843314857;
            1: return 64'sd497837829;
            2: return 64'sd263043837;
            3: return 64'sd133525159;
            4: return 64'sd67021687;
            5: return 64'sd33543516;
            6: return 64'sd16775851;
            7: return 64'sd8388437;
            8: return 64'sd4194283;
            9: return 64'sd2097149;
            default:
            begin
                if (i > 30)
                    return 64'sd0;
                return 64'sd1 <<< (30 - i);
            end
        endcase
    endfunction

    // Vectoring pass: angle of (ax, ay) in Q30, gain-scaled length in len.
    function automatic longint vector_angle(input longint ax, input longint ay,
                                            output longint len);
        longint angle;
        longint dx;
        longint dy;
        angle = 0;
        if (ax == 0 && ay == 0)
        begin
            len = 0;
            return 0;
        end
        // Turn a left-half vector by pi; a zero ordinate there reads as +pi.
        if (ax < 0)
        begin
            angle = (ay >= 0) ? HALF_TURN : -HALF_TURN;
            ax = -ax;
            ay = -ay;
        end
        for (int unsigned i = 0; i < ITERATIONS; i++)
        begin
            dx = floor_shift(ay, i);
            dy = floor_shift(ax, i);
            if (ay >= 0)
            begin
                ax = ax + dx;
                ay = ay - dy;
                angle = angle + micro_angle(i);
            end
            else
            begin
                ax = ax - dx;
                ay = ay + dy;
                angle = angle - micro_angle(i);
            end
        end
        len = ax;
        return angle;
    endfunction

    function automatic longint to_centideg(input longint angle_q30);
        return floor_shift(angle_q30 * CENTI_MUL + (64'sd1 <<< 29), 30);
    endfunction

    function automatic tilt_t predict_tilt(input logic signed [15:0] ax,
                                           input logic signed [15:0] ay,
                                           input logic signed [15:0] az);
        longint sx;
        longint len;
        longint spare;
        longint lift;
        longint roll_q30;
        longint pitch_q30;
        tilt_t  t;
        sx = ax;
        roll_q30 = vector_angle(longint'(az) * COUNT_SCALE, longint'(ay) * COUNT_SCALE, len);
        // Scale -x by the gain so it matches the gain-scaled length of (y, z).
        lift = floor_shift((-sx * COUNT_SCALE) * CORDIC_GAIN, 30);
        pitch_q30 = vector_angle(len, lift, spare);
        t.roll  = 16'(to_centideg(roll_q30));
        t.pitch = 15'(to_centideg(pitch_q30));
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus and handshakes
    // ------------------------------------------------------------------

    // Drive one sample and hold it until the block takes the beat. Valid stays high into
    // the next beat when no gap is drawn, so it is never lowered and raised in one step.
    task automatic send_sample(input logic signed [15:0] ax,
                               input logic signed [15:0] ay,
                               input logic signed [15:0] az);
        int    gap;
        tilt_t t;
        gap = calm ? 0 : $urandom_range(0, 5);
        t = predict_tilt(ax, ay, az);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        do
            @(posedge clk);
        while (!s_tready);
        pending_tilts.push_back(t);
    endtask

    // Drop valid and hold until every predicted beat has come out.
    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_tilts.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: draw a stall per beat, then hold ready until a beat is taken.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare every output beat, field by field, with the oldest prediction.
    always @(posedge clk)
    begin
        tilt_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_tilts.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected beat: expected none actual %h", $time, m_tdata);
            end
            else
            begin
                want = pending_tilts.pop_front();
                if (m_tdata[15:0] !== want.roll)
                begin
                    mismatches++;
                    $display("%0t roll_centideg: expected %0d actual %0d", $time,
                             want.roll, $signed(m_tdata[15:0]));
                end
                if (m_tdata[30:16] !== want.pitch)
                begin
                    mismatches++;
                    $display("%0t pitch_centideg: expected %0d actual %0d", $time,
                             want.pitch, $signed(m_tdata[30:16]));
                end
                if (m_tdata[31] !== 1'b0)
                begin
                    mismatches++;
                    $display("%0t pad bit: expected 0 actual %b", $time, m_tdata[31]);
                end
            end
        end
    end

    // Watchdog: end the run if the pipeline hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full-scale corners on every axis and the smallest nonzero samples, with both sides idling at random.
    task automatic test_extremes();
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
        send_sample(16'sd0, 16'sd32767, -16'sd32768);
        send_sample(16'sd0, -16'sd32768, -16'sd32768);
        send_sample(16'sd0, -16'sd32768, 16'sd32767);
        send_sample(16'sd32767, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
    endtask

    task automatic test_special_cases();
        // Zero vector for both angles.
        send_sample(16'sd0, 16'sd0, 16'sd0);
        // y = z = 0 with x set: roll is zero, pitch sees a zero-length abscissa.
        send_sample(16'sd1000, 16'sd0, 16'sd0);
        send_sample(-16'sd32768, 16'sd0, 16'sd0);
        // Negative abscissa: zero ordinate gives +pi, negative gives -pi.
        send_sample(16'sd0, 16'sd0, -16'sd16384);
        send_sample(16'sd0, -16'sd1, -16'sd16384);
        send_sample(16'sd0, 16'sd1, -16'sd16384);
        // Zero ordinate with positive abscissa.
        send_sample(16'sd0, 16'sd0, 16'sd16384);
        send_sample(16'sd16384, 16'sd0, 16'sd16384);
        // Quarter turns on the roll axis.
        send_sample(16'sd0, 16'sd16384, 16'sd0);
        send_sample(16'sd0, -16'sd16384, 16'sd0);
    endtask

    // Sensor-like samples, with full-range noise, tiny values, extremes and axis-aligned cases mixed in.
    // Every few hundred beats both sides run flat out for a stretch.
    task automatic test_random_stream();
        logic signed [15:0] a[3];
        int                 kind;
        int                 g;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            calm = (n % 320) >= 260;
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++)
            begin
                case (kind)
                    0, 1, 2:
                        a[k] = 16'($urandom);
                    3, 4, 5, 6:
                    begin
                        // Near one g at a typical sensor scale, in any direction.
                        g = $urandom_range(0, 20000);
                        a[k] = 16'($urandom_range(0, 1) ? g : -g);
                    end
                    7:
                        a[k] = 16'($signed($urandom_range(0, 8)) - 4);
                    8:
                        a[k] = ($urandom_range(0, 2) == 0) ? 16'sd0 : 16'($urandom);
                    default:
                    begin
                        case ($urandom_range(0, 4))
                            0: a[k] = -16'sd32768;
                            1: a[k] = -16'sd1;
                            2: a[k] = 16'sd0;
                            3: a[k] = 16'sd1;
                            default: a[k] = 16'sd32767;
                        endcase
                    end
                endcase
            end
            send_sample(a[0], a[1], a[2]);
        end
        calm = 1'b0;
    endtask

    // Send short bursts and let the pipeline empty completely between them.
    task automatic test_drain_pause();
        for (int b = 0; b < 3; b++)
        begin
            for (int n = 0; n < 8; n++)
                send_sample(16'($urandom), 16'($urandom), 16'($urandom));
            wait_for_drain();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_special_cases();
        test_drain_pause();
        test_random_stream();

        // Empty the pipeline, then give stray beats a chance to show up.
        wait_for_drain();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
